FILE: design/arp_pkg.sv
// Shared constants for the ARP request responder and its checker.
// No dependencies.
package arp_pkg;

	localparam int unsigned MAC_W     = 48;
	localparam int unsigned IP_W      = 32;
	localparam int unsigned CFG_W     = 48;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned REPLY_LEN = 60;
	localparam int unsigned ARP_MIN_LEN = 42;
	localparam int unsigned PAD_LEN   = REPLY_LEN - ARP_MIN_LEN;

	localparam logic [MAC_W-1:0] OWN_MAC_RST  = 48'h94DE806CEF4A;
	localparam logic [IP_W-1:0]  OWN_IPV4_RST = 32'hC0A801C9;

	localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
	localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
	localparam logic [7:0]  ARP_HLEN       = 8'd6;
	localparam logic [7:0]  ARP_PLEN       = 8'd4;
	localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
	localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;

	typedef enum logic [0:0] {
		REG_OWN_MAC  = 1'b0,
		REG_OWN_IPV4 = 1'b1
	} cfg_reg_t;

	localparam logic [POS_W-1:0] POS_MAX        = POS_W'(63);
	localparam logic [POS_W-1:0] POS_LAST_ARP   = POS_W'(ARP_MIN_LEN - 1);
	localparam logic [POS_W-1:0] REPLY_LAST_IDX = POS_W'(REPLY_LEN - 1);

endpackage

FILE: design/arp_request_responder_top.sv
// ARP request responder: parses a received ARP frame and streams a 60-byte reply.
// Depends on arp_pkg.
// A matching request's accepted last byte captures the reply addresses and starts the reply.
// Throughput: one rx beat per cycle; one tx beat per cycle when tx_stall is low; a last
// byte is stalled until the final beat of the current reply enters the output register.
// Reset (arst_n low) clears position, captures and reply control; config returns to defaults.
module arp_request_responder_top
	import arp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 rx_valid,
	output logic                 rx_stall,
	input  logic [7:0]           rx_byte,
	input  logic                 rx_last,
	output logic                 tx_valid,
	input  logic                 tx_stall,
	output logic [7:0]           tx_byte,
	output logic                 tx_last
);

	localparam int unsigned FRAME_W = 8 * REPLY_LEN;
	localparam int unsigned BASE_W  = $clog2(FRAME_W);

	logic [MAC_W-1:0] own_mac_q;
	logic [IP_W-1:0]  own_ipv4_q;

	logic [POS_W-1:0] pos_q;
	logic [MAC_W-1:0] req_mac_q;
	logic [15:0]      opcode_q;
	logic [IP_W-1:0]  req_ip_q;
	logic [IP_W-1:0]  asked_ip_q;

	logic [MAC_W-1:0] req_mac_d;
	logic [15:0]      opcode_d;
	logic [IP_W-1:0]  req_ip_d;
	logic [IP_W-1:0]  asked_ip_d;

	logic             busy_q;
	logic [POS_W-1:0] idx_q;
	logic [MAC_W-1:0] rep_mac_q;
	logic [IP_W-1:0]  rep_ip_q;

	logic             tx_valid_q;
	logic [7:0]       tx_byte_q;
	logic             tx_last_q;

	logic               rx_beat;
	logic               trigger;
	logic               load;
	logic [FRAME_W-1:0] frame;
	logic [BASE_W-1:0]  base;

	assign rx_stall = busy_q & rx_last;
	assign rx_beat  = rx_valid & ~rx_stall;

	always_comb begin
		req_mac_d  = req_mac_q;
		opcode_d   = opcode_q;
		req_ip_d   = req_ip_q;
		asked_ip_d = asked_ip_q;
		priority if (pos_q >= POS_W'(6) && pos_q < POS_W'(12)) begin
			req_mac_d = {req_mac_q[MAC_W-9:0], rx_byte};
		end else if (pos_q >= POS_W'(20) && pos_q < POS_W'(22)) begin
			opcode_d = {opcode_q[7:0], rx_byte};
		end else if (pos_q >= POS_W'(28) && pos_q < POS_W'(32)) begin
			req_ip_d = {req_ip_q[IP_W-9:0], rx_byte};
		end else if (pos_q >= POS_W'(38) && pos_q < POS_W'(42)) begin
			asked_ip_d = {asked_ip_q[IP_W-9:0], rx_byte};
		end else begin
			req_mac_d = req_mac_q;
		end
	end

	assign trigger = rx_beat & rx_last & (pos_q >= POS_LAST_ARP)
		& (opcode_d == ARP_OP_REQUEST) & (asked_ip_d == own_ipv4_q);

	assign load = busy_q & (~tx_valid_q | ~tx_stall);

	assign frame = {rep_mac_q, own_mac_q, ETH_TYPE_ARP, ARP_HTYPE_ETH, ETH_TYPE_IPV4,
		ARP_HLEN, ARP_PLEN, ARP_OP_REPLY, own_mac_q, own_ipv4_q, rep_mac_q, rep_ip_q,
		(8 * PAD_LEN)'(0)};
	assign base = BASE_W'(FRAME_W - 1) - {idx_q, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac_q  <= OWN_MAC_RST;
			own_ipv4_q <= OWN_IPV4_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OWN_MAC:  own_mac_q  <= cfg_data[MAC_W-1:0];
				REG_OWN_IPV4: own_ipv4_q <= cfg_data[IP_W-1:0];
				default:      own_mac_q  <= own_mac_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			req_mac_q  <= '0;
			opcode_q   <= '0;
			req_ip_q   <= '0;
			asked_ip_q <= '0;
		end else if (rx_beat) begin
			req_mac_q  <= req_mac_d;
			opcode_q   <= opcode_d;
			req_ip_q   <= req_ip_d;
			asked_ip_q <= asked_ip_d;
			if (rx_last) begin
				pos_q <= '0;
			end else if (pos_q != POS_MAX) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trigger) begin
			rep_mac_q <= req_mac_d;
			rep_ip_q  <= req_ip_d;
		end
		if (load) begin
			tx_byte_q <= frame[base -: 8];
			tx_last_q <= (idx_q == REPLY_LAST_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			tx_valid_q <= 1'b0;
		end else begin
			if (trigger) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load) begin
				idx_q <= idx_q + POS_W'(1);
				if (idx_q == REPLY_LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				tx_valid_q <= 1'b1;
			end else if (!tx_stall) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	assign tx_valid = tx_valid_q;
	assign tx_byte  = tx_byte_q;
	assign tx_last  = tx_last_q;

endmodule

FILE: design/arp_checker.sv
// Port-level checker for the ARP request responder, bound to the top level.
// Depends on arp_pkg and arp_request_responder_top.
module arp_checker
	import arp_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         rx_valid,
	input logic         rx_stall,
	input logic         rx_last,
	input logic         tx_valid,
	input logic         tx_stall,
	input logic [7:0]   tx_byte,
	input logic         tx_last
);

	logic [POS_W-1:0] beat_cnt_q;
	logic             tx_beat;

	assign tx_beat = tx_valid & ~tx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_cnt_q <= '0;
		end else if (tx_beat) begin
			beat_cnt_q <= tx_last ? '0 : beat_cnt_q + POS_W'(1);
		end
	end

	a_tx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && tx_stall |=> tx_valid && $stable(tx_byte) && $stable(tx_last))
		else $error("tx beat changed while stalled");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		tx_beat |-> (tx_last == (beat_cnt_q == REPLY_LAST_IDX)))
		else $error("tx_last not on the final reply beat");

	a_ethertype: assert property (@(posedge clk) disable iff (!arst_n)
		tx_beat && beat_cnt_q == POS_W'(12) |-> tx_byte == ETH_TYPE_ARP[15:8])
		else $error("reply ethertype high byte wrong");

	a_stall_last: assert property (@(posedge clk) disable iff (!arst_n)
		rx_valid && rx_stall |-> rx_last)
		else $error("rx stalled on a byte that is not the last");

endmodule

bind arp_request_responder_top arp_checker u_arp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.rx_valid (rx_valid),
	.rx_stall (rx_stall),
	.rx_last  (rx_last),
	.tx_valid (tx_valid),
	.tx_stall (tx_stall),
	.tx_byte  (tx_byte),
	.tx_last  (tx_last)
);
